// ===== rtl/bzf_pkg.sv =====
// ----------------------------------------------------------------------------
// bzf_pkg - cubic bezier flattener shared definitions
// widths, sequencer states, stack entry type and small coordinate helpers
// ----------------------------------------------------------------------------
package bzf_pkg;

	localparam int MAX_DEPTH       = 5;
	localparam int COORD_FRAC_BITS = 8;
	localparam int IN_W            = 24;
	localparam int OUT_W           = 16;

	// extra fraction bits keep every midpoint exact
	localparam int EXTRA_BITS  = 3 * (MAX_DEPTH + 1);
	localparam int TOTAL_FRAC  = COORD_FRAC_BITS + EXTRA_BITS;
	localparam int CW          = IN_W + EXTRA_BITS;     // coordinate width
	localparam int DW          = CW + 1;                // difference width
	localparam int XW          = 2 * DW;                // cross product magnitude
	localparam int SW          = XW + 1;                // sum of two cross products
	localparam int OPW         = SW;                    // multiplier operand width
	localparam int MW          = 2 * SW + 2;            // accumulator width
	localparam int CMPW        = MW + 2 * TOTAL_FRAC;   // flatness compare width
	localparam int DGW         = 8;                     // multiplier digit per cycle

	localparam int STACK_DEPTH = MAX_DEPTH + 1;
	localparam int AW          = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int TW          = $clog2(STACK_DEPTH + 1);
	localparam int LW          = $clog2(MAX_DEPTH + 2);

	typedef logic [7:0][CW-1:0] curve_t;  // x0 y0 x1 y1 x2 y2 x3 y3

	typedef struct packed {
		logic [LW-1:0] lvl;
		curve_t        pts;
	} stk_entry_t;

	typedef struct packed {
		logic start;
		logic clr;
		logic neg;
	} mac_ctl_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHECK,
		ST_M_AXDY,
		ST_M_AYDX,
		ST_M_BXDY,
		ST_M_BYDX,
		ST_M_SS,
		ST_M_DXDX,
		ST_M_DYDY,
		ST_DECIDE,
		ST_SPLIT,
		ST_EMIT,
		ST_POP,
		ST_LOAD
	} seq_state_t;

	function automatic logic [CW-1:0] mid_pt(input logic [CW-1:0] a, input logic [CW-1:0] b);
		logic [CW:0] sum;
		sum = {a[CW-1], a} + {b[CW-1], b};
		return sum[CW:1];
	endfunction

	function automatic logic [DW-1:0] mag_d(input logic [DW-1:0] v);
		return v[DW-1] ? (~v + 1'b1) : v;
	endfunction

	// round half away from zero, saturate to 16 bits
	function automatic logic [OUT_W-1:0] to_pixel(input logic [CW-1:0] v);
		logic [CW-1:0] mag;
		logic [CW:0]   m;
		logic [OUT_W-1:0] r;
		mag = v[CW-1] ? (~v + 1'b1) : v;
		m   = ({1'b0, mag} + ((CW+1)'(1) << (TOTAL_FRAC - 1))) >> TOTAL_FRAC;
		if (v[CW-1]) begin
			if (m > (CW+1)'(32768))
				r = 16'h8000;
			else
				r = OUT_W'(~m + 1'b1);
		end else begin
			if (m > (CW+1)'(32767))
				r = 16'h7fff;
			else
				r = m[OUT_W-1:0];
		end
		return r;
	endfunction

endpackage

// ===== rtl/bzf_mac.sv =====
// ----------------------------------------------------------------------------
// bzf_mac - shared multiply-accumulate unit
// digit-serial unsigned multiply, signed accumulate, one 8-bit digit a cycle
// ----------------------------------------------------------------------------
module bzf_mac
	import bzf_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  mac_ctl_t             ctl,
	input  logic [OPW-1:0]       op_a,
	input  logic [OPW-1:0]       op_b,
	output logic                 busy,
	output logic signed [MW-1:0] acc
);

	logic              busy_q;
	logic              neg_q;
	logic [MW-1:0]     mcand_q;
	logic [OPW-1:0]    mplier_q;
	logic [MW-1:0]     acc_q;
	logic [MW-1:0]     pp;

	assign pp = MW'(mcand_q * mplier_q[DGW-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (ctl.start) begin
			busy_q <= 1'b1;
		end else if (busy_q && (mplier_q == '0)) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			mcand_q  <= MW'(op_a);
			mplier_q <= op_b;
			neg_q    <= ctl.neg;
			if (ctl.clr)
				acc_q <= '0;
		end else if (busy_q && (mplier_q != '0)) begin
			acc_q    <= neg_q ? (acc_q - pp) : (acc_q + pp);
			mcand_q  <= mcand_q << DGW;
			mplier_q <= mplier_q >> DGW;
		end
	end

	assign busy = busy_q;
	assign acc  = $signed(acc_q);

endmodule

// ===== rtl/bzf_stack.sv =====
// ----------------------------------------------------------------------------
// bzf_stack - pending right halves
// one write port, one registered read port
// ----------------------------------------------------------------------------
module bzf_stack
	import bzf_pkg::*;
(
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  stk_entry_t    wdata,
	input  logic [AW-1:0] raddr,
	output stk_entry_t    rdata
);

	stk_entry_t mem [STACK_DEPTH];
	stk_entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/cubic_bezier_flattener_unit.sv =====
// ----------------------------------------------------------------------------
// cubic_bezier_flattener_unit - adaptive de casteljau cubic flattener
// splits one cubic segment at t=1/2 depth first and emits rounded end points
// of flat or depth-limited pieces in curve order
// ----------------------------------------------------------------------------
// channel   dir  tdata                                      tlast
// s_axis    in   start_x start_y ctrl1_x ctrl1_y ctrl2_x     -
//                ctrl2_y end_x end_y (24b each, q15.8)
// m_axis    out  point_x point_y (16b each)                 last_point
//
// one segment takes 1 to 64 output words; each tested piece runs seven
// products through the shared 8-bit digit multiplier, each running until its
// last significant multiplier digit; an emit waits out any output stall, a
// split returns to the test and a pop reloads the popped half before testing it
// arst_n clears the sequencer, stack pointer and level; data registers are not reset
// s_axis_tready is high only while idle; a stalled m_axis holds the sequencer
// ----------------------------------------------------------------------------
module cubic_bezier_flattener_unit
	import bzf_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [191:0] s_axis_tdata,   // start_x start_y ctrl1_x ctrl1_y ctrl2_x ctrl2_y end_x end_y
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [31:0]  m_axis_tdata,   // point_x point_y
	output logic         m_axis_tlast
);

	seq_state_t state_q, state_nxt;

	curve_t         curve_q;
	logic [LW-1:0]  lvl_q;
	logic [TW-1:0]  top_q;
	logic           issued_q;
	logic [XW-1:0]  d2_q;
	logic [SW-1:0]  s_q;
	logic [MW-1:0]  ss_q;
	logic [OUT_W-1:0] px_q, py_q;
	logic           last_q;

	// shared multiplier hookup
	mac_ctl_t              mac_ctl;
	logic [OPW-1:0]        op_a, op_b;
	logic                  mac_busy;
	logic signed [MW-1:0]  acc;
	logic                  mac_done;
	logic [MW-1:0]         acc_mag;

	// piece geometry, chord and control offsets from the end point
	logic [DW-1:0] dx, dy, ax, ay, bx, by;
	logic [DW-1:0] dx_m, dy_m, ax_m, ay_m, bx_m, by_m;
	logic          flat;

	// subdivision points
	logic [CW-1:0] p01x, p01y, p12x, p12y, p23x, p23y;
	logic [CW-1:0] pax, pay, pbx, pby, pmx, pmy;

	stk_entry_t    push_ent, pop_ent;
	logic          push_we;
	logic [TW-1:0] top_dec;

	function automatic logic [DW-1:0] sdiff(input logic [CW-1:0] a, input logic [CW-1:0] b);
		return {a[CW-1], a} - {b[CW-1], b};
	endfunction

	assign dx = sdiff(curve_q[6], curve_q[0]);
	assign dy = sdiff(curve_q[7], curve_q[1]);
	assign ax = sdiff(curve_q[2], curve_q[6]);
	assign ay = sdiff(curve_q[3], curve_q[7]);
	assign bx = sdiff(curve_q[4], curve_q[6]);
	assign by = sdiff(curve_q[5], curve_q[7]);
	assign dx_m = mag_d(dx);
	assign dy_m = mag_d(dy);
	assign ax_m = mag_d(ax);
	assign ay_m = mag_d(ay);
	assign bx_m = mag_d(bx);
	assign by_m = mag_d(by);

	assign p01x = mid_pt(curve_q[0], curve_q[2]);
	assign p01y = mid_pt(curve_q[1], curve_q[3]);
	assign p12x = mid_pt(curve_q[2], curve_q[4]);
	assign p12y = mid_pt(curve_q[3], curve_q[5]);
	assign p23x = mid_pt(curve_q[4], curve_q[6]);
	assign p23y = mid_pt(curve_q[5], curve_q[7]);
	assign pax  = mid_pt(p01x, p12x);
	assign pay  = mid_pt(p01y, p12y);
	assign pbx  = mid_pt(p12x, p23x);
	assign pby  = mid_pt(p12y, p23y);
	assign pmx  = mid_pt(pax, pbx);
	assign pmy  = mid_pt(pay, pby);

	assign mac_done = issued_q && !mac_busy;
	assign acc_mag  = acc[MW-1] ? MW'(-acc) : MW'(acc);

	// 4*S^2 < Q * 2^(2F), acc holds Q when deciding
	assign flat = ({{(CMPW-MW-2){1'b0}}, ss_q, 2'b00}) <
	              ({acc_mag[CMPW-2*TOTAL_FRAC-1:0], {(2*TOTAL_FRAC){1'b0}}});

	assign push_we        = (state_q == ST_SPLIT);
	assign push_ent.lvl   = lvl_q + 1'b1;
	assign push_ent.pts   = {curve_q[7], curve_q[6], p23y, p23x, pby, pbx, pmy, pmx};
	assign top_dec        = top_q - 1'b1;

	bzf_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mac_ctl),
		.op_a   (op_a),
		.op_b   (op_b),
		.busy   (mac_busy),
		.acc    (acc)
	);

	bzf_stack u_stack (
		.clk   (clk),
		.we    (push_we),
		.waddr (top_q[AW-1:0]),
		.wdata (push_ent),
		.raddr (top_dec[AW-1:0]),
		.rdata (pop_ent)
	);

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE:   if (s_axis_tvalid) state_nxt = ST_CHECK;
			ST_CHECK:  state_nxt = (lvl_q > LW'(MAX_DEPTH)) ? ST_EMIT : ST_M_AXDY;
			ST_M_AXDY: if (mac_done) state_nxt = ST_M_AYDX;
			ST_M_AYDX: if (mac_done) state_nxt = ST_M_BXDY;
			ST_M_BXDY: if (mac_done) state_nxt = ST_M_BYDX;
			ST_M_BYDX: if (mac_done) state_nxt = ST_M_SS;
			ST_M_SS:   if (mac_done) state_nxt = ST_M_DXDX;
			ST_M_DXDX: if (mac_done) state_nxt = ST_M_DYDY;
			ST_M_DYDY: if (mac_done) state_nxt = ST_DECIDE;
			ST_DECIDE: state_nxt = flat ? ST_EMIT : ST_SPLIT;
			ST_SPLIT:  state_nxt = ST_CHECK;
			ST_EMIT:   if (m_axis_tready) state_nxt = last_q ? ST_IDLE : ST_POP;
			ST_POP:    state_nxt = ST_LOAD;
			ST_LOAD:   state_nxt = ST_CHECK;
			default:   state_nxt = ST_IDLE;
		endcase
	end

	// multiplier operands and handshake outputs
	always_comb begin
		mac_ctl = '0;
		op_a    = '0;
		op_b    = '0;
		case (state_q)
			ST_M_AXDY: begin
				op_a = OPW'(ax_m); op_b = OPW'(dy_m);
				mac_ctl.clr = 1'b1; mac_ctl.neg = ax[DW-1] ^ dy[DW-1];
			end
			ST_M_AYDX: begin
				op_a = OPW'(ay_m); op_b = OPW'(dx_m);
				mac_ctl.neg = ~(ay[DW-1] ^ dx[DW-1]);
			end
			ST_M_BXDY: begin
				op_a = OPW'(bx_m); op_b = OPW'(dy_m);
				mac_ctl.clr = 1'b1; mac_ctl.neg = bx[DW-1] ^ dy[DW-1];
			end
			ST_M_BYDX: begin
				op_a = OPW'(by_m); op_b = OPW'(dx_m);
				mac_ctl.neg = ~(by[DW-1] ^ dx[DW-1]);
			end
			ST_M_SS: begin
				op_a = s_q; op_b = s_q; mac_ctl.clr = 1'b1;
			end
			ST_M_DXDX: begin
				op_a = OPW'(dx_m); op_b = OPW'(dx_m); mac_ctl.clr = 1'b1;
			end
			ST_M_DYDY: begin
				op_a = OPW'(dy_m); op_b = OPW'(dy_m);
			end
			default: begin
				op_a = '0;
			end
		endcase
		mac_ctl.start = ((state_q == ST_M_AXDY) || (state_q == ST_M_AYDX) ||
		                 (state_q == ST_M_BXDY) || (state_q == ST_M_BYDX) ||
		                 (state_q == ST_M_SS)   || (state_q == ST_M_DXDX) ||
		                 (state_q == ST_M_DYDY)) && !issued_q;
	end

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = (state_q == ST_EMIT);
	assign m_axis_tdata  = {py_q, px_q};
	assign m_axis_tlast  = last_q;

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			issued_q <= 1'b0;
			lvl_q    <= '0;
			top_q    <= '0;
		end else begin
			state_q <= state_nxt;
			if (mac_done)
				issued_q <= 1'b0;
			else if (mac_ctl.start)
				issued_q <= 1'b1;
			case (state_q)
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						lvl_q <= '0;
						top_q <= '0;
					end
				end
				ST_SPLIT: begin
					lvl_q <= lvl_q + 1'b1;
					top_q <= top_q + 1'b1;
				end
				ST_POP:  top_q <= top_dec;
				ST_LOAD: lvl_q <= pop_ent.lvl;
				default: top_q <= top_q;
			endcase
		end
	end

	// working curve and intermediate results
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (s_axis_tvalid) begin
					for (int i = 0; i < 8; i++)
						curve_q[i] <= {s_axis_tdata[i*IN_W +: IN_W], {EXTRA_BITS{1'b0}}};
				end
			end
			ST_SPLIT: begin
				curve_q[2] <= p01x;
				curve_q[3] <= p01y;
				curve_q[4] <= pax;
				curve_q[5] <= pay;
				curve_q[6] <= pmx;
				curve_q[7] <= pmy;
			end
			ST_LOAD: curve_q <= pop_ent.pts;
			ST_M_AYDX: if (mac_done) d2_q <= acc_mag[XW-1:0];
			ST_M_BYDX: if (mac_done) s_q <= {1'b0, d2_q} + SW'(acc_mag[XW-1:0]);
			ST_M_SS:   if (mac_done) ss_q <= acc_mag;
			default:   d2_q <= d2_q;
		endcase
		if ((state_nxt == ST_EMIT) && (state_q != ST_EMIT)) begin
			px_q   <= to_pixel(curve_q[6]);
			py_q   <= to_pixel(curve_q[7]);
			last_q <= (top_q == '0);
		end
	end

	// stack pointer never passes its depth
	a_top_bound: assert property (@(posedge clk) disable iff (!arst_n)
		top_q <= TW'(STACK_DEPTH))
		else $error("stack pointer overflow");

	// a split only at or below the depth limit
	a_split_lvl: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SPLIT) |-> (lvl_q <= LW'(MAX_DEPTH)))
		else $error("split past depth limit");

	// the marked word comes only with an empty stack
	a_last_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tlast) |-> (top_q == '0))
		else $error("last word with pending halves");

	// a pop never runs on an empty stack
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_POP) |-> (top_q != '0))
		else $error("pop on empty stack");

	// the multiplier is idle whenever a new segment is taken
	a_mac_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |-> !mac_busy)
		else $error("multiplier busy at segment start");

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench - cubic bezier flattener unit
// sends directed and random cubic segments, predicts the rounded vertex list
// of every segment by exact adaptive subdivision and checks each output word
// ----------------------------------------------------------------------------
module testbench;
	import bzf_pkg::*;

	localparam int N_RANDOM  = 480;
	localparam int WD_LIMIT  = 20000;
	localparam int FRAC_ALL  = 8 + 3 * (MAX_DEPTH + 1);

	typedef logic [7:0][IN_W-1:0] segment_t;   // sx sy c1x c1y c2x c2y ex ey
	typedef struct {
		logic [15:0] px;
		logic [15:0] py;
		logic        last;
	} vertex_t;

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [191:0] s_axis_tdata;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [31:0]  m_axis_tdata;
	logic         m_axis_tlast;

	segment_t segment_q[$];
	vertex_t  vertex_q[$];
	int       errors;
	int       sent;
	int       total_items;
	int       pause_at;
	bit       stim_done;

	cubic_bezier_flattener_unit dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// |a*d - b*c| at full width
	function automatic logic [255:0] abs_cross(longint a, longint d, longint b, longint c);
		logic signed [127:0] r;
		r = 128'(a) * 128'(d) - 128'(b) * 128'(c);
		if (r < 0)
			r = -r;
		return 256'(unsigned'(r));
	endfunction

	function automatic bit piece_flat(longint x[4], longint y[4]);
		longint dx, dy;
		logic [255:0] s, lhs, rhs;
		logic signed [127:0] q;
		dx = x[3] - x[0];
		dy = y[3] - y[0];
		s = abs_cross(x[1] - x[3], dy, y[1] - y[3], dx)
			+ abs_cross(x[2] - x[3], dy, y[2] - y[3], dx);
		lhs = (s * s) << 2;
		q = 128'(dx) * 128'(dx) + 128'(dy) * 128'(dy);
		rhs = 256'(unsigned'(q)) << (2 * FRAC_ALL);
		return lhs < rhs;
	endfunction

	function automatic logic [15:0] round_pixel(longint v);
		longint m;
		m = ((v < 0 ? -v : v) + (longint'(1) << (FRAC_ALL - 1))) >>> FRAC_ALL;
		if (v < 0)
			return (m > 32768) ? 16'h8000 : 16'(-m);
		return (m > 32767) ? 16'h7fff : 16'(m);
	endfunction

	// depth first split at t=1/2, queue the end point of every flat or depth-limited piece
	task automatic flatten_segment(segment_t seg);
		longint x[4], y[4], nx[4], ny[4];
		longint stk_x[MAX_DEPTH+1][4], stk_y[MAX_DEPTH+1][4];
		int     stk_lvl[MAX_DEPTH+1];
		int     top, lvl;
		vertex_t v;
		for (int i = 0; i < 4; i++) begin
			x[i] = longint'(signed'(seg[2*i]))   * (longint'(1) << (FRAC_ALL - 8));
			y[i] = longint'(signed'(seg[2*i+1])) * (longint'(1) << (FRAC_ALL - 8));
		end
		top = 0;
		lvl = 0;
		forever begin
			if (lvl > MAX_DEPTH || piece_flat(x, y)) begin
				v.px = round_pixel(x[3]);
				v.py = round_pixel(y[3]);
				v.last = (top == 0);
				vertex_q.insert(vertex_q.size(), v);
				if (top == 0)
					break;
				top--;
				x = stk_x[top];
				y = stk_y[top];
				lvl = stk_lvl[top];
			end else begin
				// midpoints are exact thanks to the extra fraction bits
				nx[0] = (x[0] + x[1]) / 2;  ny[0] = (y[0] + y[1]) / 2;
				nx[1] = (x[1] + x[2]) / 2;  ny[1] = (y[1] + y[2]) / 2;
				nx[2] = (x[2] + x[3]) / 2;  ny[2] = (y[2] + y[3]) / 2;
				nx[3] = (nx[0] + nx[1]) / 2; ny[3] = (ny[0] + ny[1]) / 2;
				nx[1] = (nx[1] + nx[2]) / 2; ny[1] = (ny[1] + ny[2]) / 2;
				// right half: mid, pb, p23, end
				stk_x[top][0] = (nx[3] + nx[1]) / 2;
				stk_y[top][0] = (ny[3] + ny[1]) / 2;
				stk_x[top][1] = nx[1];  stk_y[top][1] = ny[1];
				stk_x[top][2] = nx[2];  stk_y[top][2] = ny[2];
				stk_x[top][3] = x[3];   stk_y[top][3] = y[3];
				stk_lvl[top] = lvl + 1;
				x[1] = nx[0];  y[1] = ny[0];
				x[2] = nx[3];  y[2] = ny[3];
				x[3] = stk_x[top][0];  y[3] = stk_y[top][0];
				top++;
				lvl++;
			end
		end
	endtask

	function automatic segment_t rand_segment();
		segment_t s;
		int base_x, base_y, span;
		case ($urandom_range(0, 3))
			0: for (int i = 0; i < 8; i++) s[i] = IN_W'($urandom);
			1: begin
				// compact curve around a random center
				base_x = $urandom_range(0, 4000000) - 2000000;
				base_y = $urandom_range(0, 4000000) - 2000000;
				span   = 1 << $urandom_range(4, 16);
				for (int i = 0; i < 4; i++) begin
					s[2*i]   = IN_W'(base_x + $urandom_range(0, span) - span / 2);
					s[2*i+1] = IN_W'(base_y + $urandom_range(0, span) - span / 2);
				end
			end
			2: begin
				// nearly straight: controls on the chord plus small noise
				for (int i = 0; i < 8; i += 6) s[i] = IN_W'($urandom_range(0, 2000000));
				s[1] = IN_W'($urandom_range(0, 2000000));
				s[7] = IN_W'($urandom_range(0, 2000000));
				for (int k = 1; k < 3; k++) begin
					s[2*k]   = IN_W'((int'(s[0]) * (3 - k) + int'(s[6]) * k) / 3
						+ $urandom_range(0, 64) - 32);
					s[2*k+1] = IN_W'((int'(s[1]) * (3 - k) + int'(s[7]) * k) / 3
						+ $urandom_range(0, 64) - 32);
				end
			end
			default: begin
				// coincident or near coincident points
				s[0] = IN_W'($urandom);
				s[1] = IN_W'($urandom);
				for (int i = 2; i < 8; i++)
					s[i] = s[i % 2] + IN_W'($urandom_range(0, 1) ? $urandom_range(0, 3) : 0);
			end
		endcase
		return s;
	endfunction

	// stimulus
	initial begin
		segment_t s;
		errors = 0;
		stim_done = 0;
		s = '0;                                  segment_q.insert(segment_q.size(), s);  // degenerate
		s = {8{24'h7fffff}};                     segment_q.insert(segment_q.size(), s);
		s = {8{24'h800000}};                     segment_q.insert(segment_q.size(), s);
		s = {8{24'h123456}};                     segment_q.insert(segment_q.size(), s);
		s = {24'h7fffff, 24'h800000, 24'h800000, 24'h7fffff,
			24'h7fffff, 24'h800000, 24'h800000, 24'h7fffff};
		segment_q.insert(segment_q.size(), s);                            // saturation
		s = {24'h555555, 24'haaaaaa, 24'haaaaaa, 24'h555555,
			24'h555555, 24'haaaaaa, 24'haaaaaa, 24'h555555};
		segment_q.insert(segment_q.size(), s);
		s = {24'd2560, 24'd2560, 24'd1792, 24'd1792,
			24'd768, 24'd768, 24'd0, 24'd0};
		segment_q.insert(segment_q.size(), s);                            // straight line
		s = {24'd0, 24'd25600, 24'd25600, 24'd25600,
			24'd25600, 24'd0, 24'd0, 24'd0};
		segment_q.insert(segment_q.size(), s);                            // arch, both controls on one side
		s = {24'd128, 24'd384, 24'hffff80, 24'd128,
			24'd640, 24'hfffe80, 24'd128, 24'hffff80};
		segment_q.insert(segment_q.size(), s);                            // half pixel rounding
		s = {24'd0, 24'h7fffff, 24'd0, 24'h800000,
			24'd0, 24'h7fffff, 24'd0, 24'h800000};
		segment_q.insert(segment_q.size(), s);                            // collinear, back and forth across the full range
		for (int i = 0; i < 8; i++)
			segment_q.insert(segment_q.size(), rand_segment());
		for (int i = 0; i < N_RANDOM; i++)
			segment_q.insert(segment_q.size(), rand_segment());
		total_items = segment_q.size();
		pause_at = total_items / 2;

		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		wait (segment_q.size() == 0 && !s_axis_tvalid);
		wait (vertex_q.size() == 0);
		repeat (300) @(posedge clk);
		stim_done = 1;
		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// segment driver
	int gap_left;
	always @(posedge clk or negedge arst_n) begin
		logic     nv;
		segment_t cur;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= '0;
			sent     <= 0;
			gap_left <= 0;
		end else begin
			nv = s_axis_tvalid;
			if (s_axis_tvalid && s_axis_tready) begin
				cur = segment_q.pop_front();
				flatten_segment(cur);
				sent <= sent + 1;
				nv = 1'b0;
				if (sent < total_items - 60 && $urandom_range(0, 3) == 0)
					gap_left <= $urandom_range(1, 10);
			end else if (!s_axis_tvalid) begin
				if (gap_left > 0)
					gap_left <= gap_left - 1;
				else if (segment_q.size() > 0 && !(sent == pause_at && vertex_q.size() > 0)) begin
					s_axis_tdata <= segment_q[0];
					nv = 1'b1;
				end
			end
			s_axis_tvalid <= nv;
		end
	end

	// vertex monitor with random backpressure
	int stall_left;
	always @(posedge clk or negedge arst_n) begin
		vertex_t want;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			stall_left <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (vertex_q.size() == 0) begin
					errors++;
					$display("%0t: expected no word, actual x=%0d y=%0d last=%0b", $realtime,
						$signed(m_axis_tdata[15:0]), $signed(m_axis_tdata[31:16]), m_axis_tlast);
				end else begin
					want = vertex_q.pop_front();
					if (m_axis_tdata[15:0] !== want.px) begin
						errors++;
						$display("%0t: point_x expected %0d actual %0d", $realtime,
							$signed(want.px), $signed(m_axis_tdata[15:0]));
					end
					if (m_axis_tdata[31:16] !== want.py) begin
						errors++;
						$display("%0t: point_y expected %0d actual %0d", $realtime,
							$signed(want.py), $signed(m_axis_tdata[31:16]));
					end
					if (m_axis_tlast !== want.last) begin
						errors++;
						$display("%0t: last_point expected %0b actual %0b", $realtime,
							want.last, m_axis_tlast);
					end
				end
			end
			if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				m_axis_tready <= (stall_left == 1);
			end else if (sent < total_items - 60 && $urandom_range(0, 7) == 0) begin
				stall_left <= $urandom_range(1, 10);
				m_axis_tready <= 1'b0;
			end else
				m_axis_tready <= 1'b1;
		end
	end

	// watchdog on cycles without any accepted word
	int quiet;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			quiet <= 0;
		else if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet <= 0;
		else if (quiet >= WD_LIMIT && !stim_done) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end else
			quiet <= quiet + 1;
	end

endmodule
